// ===== src/huf_pkg.sv =====
// Shared types and constants for the Huffman table encoder and bit packer.
// No dependencies; every other source file but huf_ram imports this package.
package huf_pkg;

  localparam int BYTE_W      = 8;
  localparam int PEND_W      = 7;
  localparam int CNT_W       = 3;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;
  localparam int SYM_W       = 8;
  localparam int ACT_W       = 2;
  localparam int ACC_W       = PEND_W + CODE_W;
  localparam int REM_W       = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Input action codes; the fourth code is unused and ignored.
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  // Work handed from the front end to the packer.
  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } item_t;

  typedef struct packed {
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// ===== src/huf_in_if.sv =====
// Input channel of the Huffman encoder: valid/ready plus the command word.
// Depends on huf_pkg.
interface huf_in_if;
  import huf_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_size;

  modport source (output valid, output action, output symbol, output code_bits,
                  output code_size, input ready);
  modport sink   (input valid, input action, input symbol, input code_bits,
                  input code_size, output ready);
endinterface

// ===== src/huf_out_if.sv =====
// Output channel of the Huffman encoder: valid/ready plus one packed byte.
// Depends on huf_pkg.
interface huf_out_if;
  import huf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/huf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module huf_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/huf_fifo.sv =====
// Short queue of packer work between the front end and the packer.
// Depends on huf_pkg.
module huf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  huf_pkg::item_t  push_item_i,
  input  logic            pop_i,
  output huf_pkg::item_t  head_o,
  output huf_pkg::q_stat_t stat_o
);
  import huf_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o          = mem_q[rd_ptr_q];
  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.count    = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QUEUE_DEPTH)) || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");

endmodule

// ===== src/huf_front.sv =====
// Front end: accepts commands, keeps the code table, looks up codes and
// queues encode/flush work. Depends on huf_pkg, huf_in_if and huf_ram.
module huf_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  huf_in_if.sink           in_i,
  input  huf_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output huf_pkg::item_t   push_item_o
);
  import huf_pkg::*;

  localparam int TblAw  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LenCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int RamW   = CODE_W + LEN_W;

  logic                    accept;
  logic                    in_range;
  logic [TblAw-1:0]        addr;
  logic [LEN_W-1:0]        len_sat;
  logic                    tbl_we;
  logic                    tbl_re;
  logic [RamW-1:0]         rdata;
  logic [SYMBOL_COUNT-1:0] tbl_vld_q;
  logic                    s1_valid_q, s1_valid_d;
  op_e                     s1_op_q, s1_op_d;
  logic                    s1_hit_q, s1_hit_d;
  logic [QCNT_W:0]         in_flight;

  // Leave room in the queue for the lookup still in flight.
  assign in_flight  = {1'b0, q_stat_i.count} + (QCNT_W+1)'(s1_valid_q);
  assign in_i.ready = in_flight < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept     = in_i.valid && in_i.ready;

  assign in_range = {1'b0, in_i.symbol} < (SYM_W+1)'(SYMBOL_COUNT);
  assign addr     = TblAw'(in_i.symbol);
  assign len_sat  = (in_i.code_size > LEN_W'(LenCap)) ? LEN_W'(LenCap) : in_i.code_size;

  always_comb begin
    tbl_we     = 1'b0;
    tbl_re     = 1'b0;
    s1_valid_d = 1'b0;
    s1_op_d    = OP_ENCODE;
    s1_hit_d   = 1'b0;
    case (in_i.action)
      ACT_LOAD: begin
        tbl_we = accept && in_range;
      end
      ACT_ENCODE: begin
        tbl_re     = accept && in_range;
        s1_valid_d = accept && in_range;
        s1_hit_d   = in_range && tbl_vld_q[addr];
      end
      ACT_FLUSH: begin
        s1_valid_d = accept;
        s1_op_d    = OP_FLUSH;
      end
      default: begin
        // unused action: drop
      end
    endcase
  end

  huf_ram #(
    .WIDTH(RamW),
    .DEPTH(SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(addr),
    .wdata_i({in_i.code_bits, len_sat}),
    .re_i   (tbl_re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q  <= '0;
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_ENCODE;
      s1_hit_q   <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_q[addr] <= 1'b1;
      end
      s1_valid_q <= s1_valid_d;
      s1_op_q    <= s1_op_d;
      s1_hit_q   <= s1_hit_d;
    end
  end

  // An entry never loaded reads as length zero.
  always_comb begin
    push_item_o.op   = s1_op_q;
    push_item_o.word = rdata[RamW-1:LEN_W];
    push_item_o.len  = (s1_hit_q && (s1_op_q == OP_ENCODE)) ? rdata[LEN_W-1:0] : '0;
  end

  // Drop encodes that add no bits.
  assign push_o = s1_valid_q && ((s1_op_q == OP_FLUSH) || (push_item_o.len != '0));

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat_i.count == QCNT_W'(QUEUE_DEPTH)) |-> !in_i.ready)
    else $error("input ready while queue full");

endmodule

// ===== src/huf_back.sv =====
// Packer: merges code bits into the pending byte and sends bytes, one per
// cycle unless out_o stalls, through an output register. Depends on huf_pkg, huf_out_if.
module huf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  huf_pkg::item_t   head_i,
  input  huf_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  huf_out_if.source        out_o
);
  import huf_pkg::*;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic              ov_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;

  logic              out_free;
  logic              busy;
  logic              emit;
  logic [BYTE_W-1:0] byte_d;
  logic              last_d;
  logic [CNT_W-1:0]  cnt;
  logic [PEND_W-1:0] pend;
  logic [CODE_W:0]   one_w;
  logic [CODE_W-1:0] code_mask;
  logic [ACC_W-1:0]  merged;
  logic [REM_W-1:0]  merged_rem;
  logic [BYTE_W-1:0] flush_byte;

  assign out_free = !ov_q || out_o.ready;
  assign busy     = rem_q >= REM_W'(BYTE_W);

  // Pending bits are the low bits of the accumulator when not busy.
  assign cnt        = rem_q[CNT_W-1:0];
  assign pend       = acc_q[PEND_W-1:0] & PEND_W'((8'd1 << cnt) - 8'd1);
  assign one_w      = (CODE_W+1)'(1);
  assign code_mask  = CODE_W'((one_w << head_i.len) - one_w);
  assign merged     = (ACC_W'(pend) << head_i.len) | ACC_W'(head_i.word & code_mask);
  assign merged_rem = rem_q + REM_W'(head_i.len);
  assign flush_byte = BYTE_W'(pend) << (4'(BYTE_W) - {1'b0, cnt});

  always_comb begin
    pop_o  = 1'b0;
    emit   = 1'b0;
    byte_d = byte_q;
    last_d = last_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (busy) begin
      // drain the bytes still held from the current code
      if (out_free) begin
        emit   = 1'b1;
        byte_d = BYTE_W'(acc_q >> (rem_q - REM_W'(BYTE_W)));
        rem_d  = rem_q - REM_W'(BYTE_W);
        last_d = rem_d < REM_W'(BYTE_W);
      end
    end else if (q_stat_i.nonempty && out_free) begin
      pop_o = 1'b1;
      unique case (head_i.op)
        OP_ENCODE: begin
          acc_d = merged;
          rem_d = merged_rem;
          if (merged_rem >= REM_W'(BYTE_W)) begin
            emit   = 1'b1;
            byte_d = BYTE_W'(merged >> (merged_rem - REM_W'(BYTE_W)));
            rem_d  = merged_rem - REM_W'(BYTE_W);
            last_d = rem_d < REM_W'(BYTE_W);
          end
        end
        OP_FLUSH: begin
          rem_d = '0;
          if (cnt != '0) begin
            emit   = 1'b1;
            byte_d = flush_byte;
            last_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (out_free) begin
        ov_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = byte_q;
  assign out_o.last     = last_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= REM_W'(ACC_W))
    else $error("bit count beyond accumulator");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !last_q) |-> rem_q >= REM_W'(BYTE_W))
    else $error("non-final byte without a full byte behind it");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> $stable(rem_q))
    else $error("packer advanced while output stalled");

endmodule

// ===== src/huffman_table_encoder_packer.sv =====
// Top level of the Huffman table encoder and MSB-first bit packer.
// Depends on huf_pkg, huf_in_if, huf_out_if, huf_front, huf_fifo and huf_back.
//
// Usage
//   in_i  : valid/ready command channel. action selects load (write one code
//           table entry: symbol, code_bits, code_size), encode (append the
//           symbol's code to the bit stream) or flush (send the partial byte,
//           zero padded at the low end). The unused action code is dropped.
//   out_o : valid/ready byte channel, earliest bit in the MSB; last marks the
//           final byte produced by one command.
//   Path: an accepted encode passes the registered lookup, the queue and the
//   output register before its first byte shows on out_o.
//   Throughput: one command per cycle while each makes at most one byte and
//   out_o is not stalled; a command that makes more bytes holds the packer
//   until all are sent, one byte a cycle through its output register.
//   Reset: the code-length table reads as empty (per-entry valid flags clear)
//   and no bits are pending; the block is ready straight after reset.
//   Stall: while out_o is held off, the packer holds its byte and the queue
//   fills; in_i drops ready once the queue has no room for the lookup in
//   flight. Loads keep pace with the front end but still wait on that queue.
module huffman_table_encoder_packer #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  huf_in_if.sink    in_i,
  huf_out_if.source out_o
);
  import huf_pkg::*;

  logic    push;
  item_t   push_item;
  logic    pop;
  item_t   head;
  q_stat_t q_stat;

  // Front end: table writes, code lookup, classification.
  huf_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_item_o(push_item)
  );

  // Decouple lookup from packing so either side may stall alone.
  huf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Packer: pending bits, byte extraction, output register.
  huf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .q_stat_i(q_stat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/huf_byte_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Huffman table encoder: watches the command and byte channels,
// predicts each packed byte and compares it. Depends on huf_pkg and the two interfaces.
module huf_byte_checker #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  huf_in_if    cmd_i,
  huf_out_if   byte_i,
  output int   fail_count_o,
  output int   bytes_pending_o
);
  import huf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } coded_byte_t;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [CODE_W-1:0] code_word [SYMBOL_COUNT];
  logic [LEN_W-1:0]  code_len  [SYMBOL_COUNT];
  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_cnt;
  coded_byte_t       awaited_bytes [$];
  coded_byte_t       oldest;
  int                mismatches;

  function automatic logic [63:0] low_ones(input int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Apply one accepted word to the table and the bit packer; queue its bytes.
  task automatic pack_command(input logic [ACT_W-1:0]  act,
                              input logic [SYM_W-1:0]  sym,
                              input logic [CODE_W-1:0] bits,
                              input logic [LEN_W-1:0]  len_in);
    int          len;
    int          count;
    int          n;
    logic [63:0] acc;
    coded_byte_t made [4];
    n   = 0;
    len = len_in;
    case (act)
      ACT_LOAD: begin
        if (sym < SYMBOL_COUNT) begin
          if (len > LEN_CAP) len = LEN_CAP;
          code_len[sym]  = LEN_W'(len);
          code_word[sym] = CODE_W'(64'(bits) & low_ones(len));
        end
      end
      ACT_ENCODE: begin
        if (sym < SYMBOL_COUNT && code_len[sym] != 0) begin
          len = code_len[sym];
          if (len > LEN_CAP) len = LEN_CAP;
          acc   = (64'(pend_bits) << len) | (64'(code_word[sym]) & low_ones(len));
          count = int'(pend_cnt) + len;
          while (count >= BYTE_W && n < 4) begin
            count         -= BYTE_W;
            made[n].value  = BYTE_W'(acc >> count);
            made[n].last   = 1'b0;
            n++;
          end
          if (n > 0) made[n-1].last = 1'b1;
          for (int i = 0; i < n; i++) awaited_bytes.push_back(made[i]);
          pend_bits = PEND_W'(acc & low_ones(count));
          pend_cnt  = CNT_W'(count);
        end
      end
      ACT_FLUSH: begin
        if (pend_cnt != 0) begin
          made[0].value = BYTE_W'(16'(pend_bits) << (BYTE_W - int'(pend_cnt)));
          made[0].last  = 1'b1;
          awaited_bytes.push_back(made[0]);
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Check the outgoing byte before the incoming word: no byte can stem from a
  // word accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SYMBOL_COUNT; s++) begin
        code_word[s] = '0;
        code_len[s]  = '0;
      end
      pend_bits = '0;
      pend_cnt  = '0;
      awaited_bytes.delete();
      mismatches = 0;
      fail_count_o    <= 0;
      bytes_pending_o <= 0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        if (awaited_bytes.size() == 0) begin
          $error("out_byte: expected no byte, actual 0x%02h", byte_i.out_byte);
          mismatches++;
        end else begin
          oldest = awaited_bytes.pop_front();
          if (byte_i.out_byte !== oldest.value) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", oldest.value, byte_i.out_byte);
            mismatches++;
          end
          if (byte_i.last !== oldest.last) begin
            $error("last: expected %0b, actual %0b", oldest.last, byte_i.last);
            mismatches++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        pack_command(cmd_i.action, cmd_i.symbol, cmd_i.code_bits, cmd_i.code_size);
      fail_count_o    <= mismatches;
      bytes_pending_o <= awaited_bytes.size();
    end
  end

endmodule

// ===== tb/huffman_table_encoder_packer_test.sv =====
`timescale 1ns / 1ps
// Top of the Huffman table encoder test: drives command words, throttles the
// byte channel and gives the verdict. Depends on huf_pkg, the interfaces and huf_byte_checker.
module huffman_table_encoder_packer_test;
  import huf_pkg::*;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  // The fourth action code has no meaning; the block must drop it.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   bytes_pending;
  // Set to run a stretch of words with no gaps on that side.
  bit   steady_in;
  bit   steady_out;
  // Symbols that hold a code, so that most encodes make bytes.
  logic [SYM_W-1:0] coded_syms [$];

  huf_in_if  cmd_if ();
  huf_out_if byte_if ();

  huffman_table_encoder_packer #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (byte_if)
  );

  huf_byte_checker #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_if),
    .byte_i         (byte_if),
    .fail_count_o   (fail_count),
    .bytes_pending_o(bytes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Present one command word at a falling edge and hold it until accepted.
  // Valid is only lowered when a gap is drawn, so a back-to-back word never
  // sees valid dropped and raised in the same step.
  task automatic issue_command(input logic [ACT_W-1:0]  act,
                               input logic [SYM_W-1:0]  sym,
                               input logic [CODE_W-1:0] bits,
                               input logic [LEN_W-1:0]  len);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.action    <= act;
    cmd_if.symbol    <= sym;
    cmd_if.code_bits <= bits;
    cmd_if.code_size <= len;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int               pick;
    int               sel;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.action    = ACT_LOAD;
    cmd_if.symbol    = '0;
    cmd_if.code_bits = '0;
    cmd_if.code_size = '0;
    steady_in        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Encode before any load and flush with nothing pending:
    // both must stay silent.
    issue_command(ACT_ENCODE, 8'd5, '0, '0);
    issue_command(ACT_FLUSH, '0, '0, '0);
    // Table loads: one-bit code with junk above it, full 32-bit code,
    // over-long lengths that saturate, a seven-bit code, no code, all-zero code.
    issue_command(ACT_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd1);
    issue_command(ACT_LOAD, 8'd255, 32'hA5C3_0F69, 6'd32);
    issue_command(ACT_LOAD, 8'd1, 32'h1234_5678, 6'd40);
    issue_command(ACT_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd63);
    issue_command(ACT_LOAD, 8'd3, 32'h0000_0055, 6'd7);
    issue_command(ACT_LOAD, 8'd4, 32'h0000_DEAD, 6'd0);
    issue_command(ACT_LOAD, 8'd6, 32'h0000_0000, 6'd8);
    // One bit then seven: exactly one full byte. Then a 32-bit code on an empty
    // byte (four bytes) and on one pending bit (four bytes, one bit left over).
    issue_command(ACT_ENCODE, 8'd0, '0, '0);
    issue_command(ACT_ENCODE, 8'd3, '0, '0);
    issue_command(ACT_ENCODE, 8'd255, '0, '0);
    issue_command(ACT_ENCODE, 8'd0, '0, '0);
    issue_command(ACT_ENCODE, 8'd255, '0, '0);
    issue_command(ACT_ENCODE, 8'd1, '0, '0);
    issue_command(ACT_ENCODE, 8'd2, '0, '0);
    issue_command(ACT_ENCODE, 8'd4, '0, '0);
    issue_command(ACT_ENCODE, 8'd6, '0, '0);
    // Flush the partial byte, then flush again with nothing pending.
    issue_command(ACT_FLUSH, '0, '0, '0);
    issue_command(ACT_FLUSH, '0, '0, '0);
    issue_command(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
    issue_command(ACT_ENCODE, 8'd3, '0, '0);
    issue_command(ACT_FLUSH, '0, '0, '0);
    coded_syms = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd6};

    // Random part: mostly encodes of coded symbols, with loads, flushes and
    // the odd unused action mixed in.
    for (int k = 0; k < 260; k++) begin
      if (k % 32 == 0) steady_in = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        sym = SYM_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 19);
        if (sel == 0)      len = '0;
        else if (sel == 1) len = LEN_W'($urandom_range(33, 63));
        else if (sel < 6)  len = LEN_W'($urandom_range(13, 32));
        else               len = LEN_W'($urandom_range(1, 12));
        if (len != 0) coded_syms.push_back(sym);
        issue_command(ACT_LOAD, sym, $urandom, len);
      end else if (pick < 84) begin
        if ($urandom_range(0, 4) != 0)
          sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
        else
          sym = SYM_W'($urandom_range(0, 255));
        // The code fields carry noise here; an encode must ignore them.
        issue_command(ACT_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
      end else if (pick < 96) begin
        issue_command(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      end else begin
        issue_command(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      end
    end
    cmd_if.valid <= 1'b0;

    // Drain: wait for every predicted byte, then keep the clock running so
    // that a stray byte still in the pipeline is caught.
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("huffman_table_encoder_packer verification clean");
    end else begin
      $display("huffman_table_encoder_packer verification failed");
    end
    $finish;
  end

  // Byte sink: draw a stall before each word, with calm stretches now and then.
  initial begin : byte_sink
    int stall;
    int taken;
    byte_if.ready = 1'b0;
    steady_out    = 1'b0;
    taken         = 0;
    @(negedge clk_i);
    forever begin
      if (taken % 24 == 0) steady_out = ($urandom_range(0, 3) == 0);
      stall = steady_out ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        byte_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      byte_if.ready <= 1'b1;
      do @(posedge clk_i); while (!byte_if.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("huffman_table_encoder_packer verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/huf_pkg.sv
src/huf_in_if.sv
src/huf_out_if.sv
src/huf_ram.sv
src/huf_fifo.sv
src/huf_front.sv
src/huf_back.sv
src/huffman_table_encoder_packer.sv
tb/huf_byte_checker.sv
tb/huffman_table_encoder_packer_test.sv
